// ===== rtl/point_height_grid_binning_defines.svh =====
// Assertion macros shared by the point height grid binning block.
`ifndef POINT_HEIGHT_GRID_BINNING_DEFINES_SVH
`define POINT_HEIGHT_GRID_BINNING_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PHGB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PHGB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/phgb_pkg.sv =====
// Shared types, codes and constants of the point height grid binning block.
`timescale 1ns / 1ps

package phgb_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;
    localparam int QDEPTH       = 4;
    localparam int FRAC_BITS    = 24;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RESOLUTION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_CEILING   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_THRESHOLD = 3'd6;

    localparam logic [24:0]        RST_INV_RESOLUTION = 25'd838861;
    localparam logic [8:0]         RST_GRID_WIDTH     = 9'd256;
    localparam logic [8:0]         RST_GRID_HEIGHT    = 9'd256;
    localparam logic signed [31:0] RST_CEILING        = 32'sd3000;

    typedef struct packed {
        logic              command;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
        logic [7:0]        read_col;
        logic [7:0]        read_row;
        logic              clear_after_read;
    } t_item;

    typedef struct packed {
        logic        occupied;
        logic        exceeds_threshold;
        logic [31:0] height_span;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
    } t_result;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [24:0]        inv_resolution;
        logic [8:0]         grid_width;
        logic [8:0]         grid_height;
        logic signed [31:0] height_ceiling;
        logic [31:0]        height_threshold;
    } t_cfg;

    typedef struct packed {
        logic               is_read;
        logic               hit;
        logic               clear;
        logic signed [31:0] z;
        logic [23:0]        rgb;
    } t_op;

    typedef struct packed {
        logic signed [31:0] min_h;
        logic signed [31:0] max_h;
        logic [23:0]        color;
    } t_cell;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_MODIFY
    } t_bstate;

endpackage

// ===== rtl/phgb_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module phgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/phgb_queue.sv =====
// Short FIFO that decouples the classifying front from the cell update back.
`timescale 1ns / 1ps

module phgb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty
);

    localparam int PW   = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNTW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== rtl/phgb_front.sv =====
// Front pipeline: accept items, scale coordinates to a cell and classify.
`timescale 1ns / 1ps

module phgb_front #(
    parameter int MAX_COLS = phgb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = phgb_pkg::MAX_ROWS_DEF,
    parameter int AW       = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  phgb_pkg::t_item   i_item,
    output logic              o_full,
    input  phgb_pkg::t_cfg    i_cfg,
    input  logic              i_clearing,
    output logic              o_q_push,
    output logic [AW-1:0]     o_q_addr,
    output phgb_pkg::t_op     o_q_op,
    input  logic              i_q_full
);

    localparam int          FB    = phgb_pkg::FRAC_BITS;
    localparam logic [33:0] MAXC  = 34'(MAX_COLS);
    localparam logic [33:0] MAXR  = 34'(MAX_ROWS);

    logic                r_v1;
    phgb_pkg::t_item     r_it1;
    logic signed [32:0]  r_dx1;
    logic signed [32:0]  r_dy1;

    logic                r_v2;
    phgb_pkg::t_item     r_it2;
    logic signed [58:0]  r_px2;
    logic signed [58:0]  r_py2;

    logic                advance;
    logic                accept;
    logic signed [25:0]  inv_s;
    logic                is_read;
    logic                keep;
    logic                col_ok;
    logic                row_ok;
    logic                z_ok;
    logic                hit;
    logic [33:0]         w_lim;
    logic [33:0]         h_lim;
    logic [33:0]         colv;
    logic [33:0]         rowv;
    logic [33:0]         col_sel;
    logic [33:0]         row_sel;

    assign inv_s   = $signed({1'b0, i_cfg.inv_resolution});
    assign advance = !r_v2 || !keep || !i_q_full;
    assign o_full  = i_clearing || !advance;
    assign accept  = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (advance) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_it1 <= i_item;
            r_dx1 <= $signed({i_item.point_x[31], i_item.point_x})
                   - $signed({i_cfg.origin_x[31], i_cfg.origin_x});
            r_dy1 <= $signed({i_cfg.origin_y[31], i_cfg.origin_y})
                   - $signed({i_item.point_y[31], i_item.point_y});
            r_it2 <= r_it1;
            r_px2 <= r_dx1 * inv_s;
            r_py2 <= r_dy1 * inv_s;
        end
    end

    always_comb begin
        w_lim = ({25'd0, i_cfg.grid_width} < MAXC) ? {25'd0, i_cfg.grid_width} : MAXC;
        h_lim = ({25'd0, i_cfg.grid_height} < MAXR) ? {25'd0, i_cfg.grid_height} : MAXR;

        // A negative product inside one cell width truncates to index zero.
        colv   = r_px2[58] ? 34'd0 : r_px2[57:FB];
        col_ok = (r_px2[58] ? ((&r_px2[58:FB]) && (|r_px2[FB-1:0])) : 1'b1)
                 && (colv < w_lim);
        rowv   = r_py2[58] ? 34'd0 : r_py2[57:FB];
        row_ok = (r_py2[58] ? ((&r_py2[58:FB]) && (|r_py2[FB-1:0])) : 1'b1)
                 && (rowv < h_lim);
        z_ok   = (r_it2.point_z <= i_cfg.height_ceiling);

        is_read = (r_it2.command == phgb_pkg::CMD_READ);
        hit     = (34'(r_it2.read_col) < MAXC) && (34'(r_it2.read_row) < MAXR);
        keep    = is_read || (col_ok && row_ok && z_ok);

        col_sel = is_read ? 34'(r_it2.read_col) : colv;
        row_sel = is_read ? 34'(r_it2.read_row) : rowv;
    end

    assign o_q_push       = r_v2 && keep && !i_q_full;
    assign o_q_addr       = AW'(row_sel * MAXC + col_sel);
    assign o_q_op.is_read = is_read;
    assign o_q_op.hit     = is_read ? hit : 1'b1;
    assign o_q_op.clear   = is_read && r_it2.clear_after_read;
    assign o_q_op.z       = r_it2.point_z;
    assign o_q_op.rgb     = {r_it2.red_in, r_it2.green_in, r_it2.blue_in};

endmodule

// ===== rtl/phgb_back.sv =====
// Back end: clearing pass and read-modify-write of the cell memories.
`timescale 1ns / 1ps

module phgb_back #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    output logic               o_clearing,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [AW-1:0]      i_q_addr,
    input  phgb_pkg::t_op      i_q_op,
    input  logic [31:0]        i_threshold,
    output logic               o_empty,
    input  logic               i_pop,
    output phgb_pkg::t_result  o_result
);

    localparam int CELLW = $bits(phgb_pkg::t_cell);

    phgb_pkg::t_bstate  r_state;
    phgb_pkg::t_bstate  n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      n_clr_addr;
    logic [AW-1:0]      r_addr;
    phgb_pkg::t_op      r_op;
    logic               r_res_valid;
    phgb_pkg::t_result  r_res;

    logic               occ_we;
    logic [AW-1:0]      occ_waddr;
    logic               occ_wdata;
    logic [0:0]         occ_q;
    logic               cell_we;
    phgb_pkg::t_cell    cell_new;
    logic [CELLW-1:0]   cell_q;
    phgb_pkg::t_cell    cell_old;
    logic               res_load;
    phgb_pkg::t_result  res_data;
    logic [31:0]        span;
    logic               z_new_max;

    phgb_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_re    (o_q_pop),
        .i_raddr (i_q_addr),
        .o_rdata (occ_q)
    );

    phgb_ram #(.WIDTH(CELLW), .DEPTH(DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (r_addr),
        .i_wdata (cell_new),
        .i_re    (o_q_pop),
        .i_raddr (i_q_addr),
        .o_rdata (cell_q)
    );

    assign cell_old  = phgb_pkg::t_cell'(cell_q);
    assign span      = cell_old.max_h - cell_old.min_h;
    assign z_new_max = !occ_q[0] || (r_op.z > cell_old.max_h);

    always_comb begin
        cell_new.min_h = (!occ_q[0] || (r_op.z < cell_old.min_h)) ? r_op.z : cell_old.min_h;
        cell_new.max_h = z_new_max ? r_op.z : cell_old.max_h;
        cell_new.color = z_new_max ? r_op.rgb : cell_old.color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phgb_pkg::B_CLEAR;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_addr <= i_q_addr;
            r_op   <= i_q_op;
        end
        if (res_load) begin
            r_res <= res_data;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        o_clearing = 1'b0;
        o_q_pop    = 1'b0;
        occ_we     = 1'b0;
        occ_waddr  = r_addr;
        occ_wdata  = 1'b0;
        cell_we    = 1'b0;
        res_load   = 1'b0;
        res_data   = '0;
        unique case (r_state)
            phgb_pkg::B_CLEAR: begin
                o_clearing = 1'b1;
                occ_we     = 1'b1;
                occ_waddr  = r_clr_addr;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = phgb_pkg::B_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            phgb_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = phgb_pkg::B_MODIFY;
                end
            end
            phgb_pkg::B_MODIFY: begin
                if (!r_op.is_read) begin
                    cell_we   = 1'b1;
                    occ_we    = 1'b1;
                    occ_wdata = 1'b1;
                    n_state   = phgb_pkg::B_IDLE;
                end else if (!r_res_valid || i_pop) begin
                    res_load = 1'b1;
                    if (r_op.hit && occ_q[0]) begin
                        res_data.occupied          = 1'b1;
                        res_data.exceeds_threshold = (span > i_threshold);
                        res_data.height_span       = span;
                        res_data.red_out           = cell_old.color[23:16];
                        res_data.green_out         = cell_old.color[15:8];
                        res_data.blue_out          = cell_old.color[7:0];
                    end
                    occ_we  = r_op.hit && r_op.clear;
                    n_state = phgb_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = phgb_pkg::B_IDLE;
            end
        endcase
    end

    assign o_empty  = !r_res_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/point_height_grid_binning.sv =====
// Top level of the point height grid binning block.
`timescale 1ns / 1ps
`include "point_height_grid_binning_defines.svh"

// Bins points into a bird's-eye grid of MAX_COLS x MAX_ROWS cells and answers cell
// reads. After reset the block sweeps all MAX_COLS * MAX_ROWS cells of the occupancy
// memory once, one cell a cycle, with full held high; configuration writes are taken
// during the sweep. The front takes one item per cycle while the queue has room and
// no sweep runs, and classifies it through a subtract stage and a multiply stage,
// then hands it to a four-entry queue. The back pops a queued item in its idle state,
// reading the cell memories through their registered read port, and updates or
// reports the cell in its modify state; it pops no new item before the last is done,
// and a read waits there while the previous result is unpopped. A read result waits
// in an output register until popped; dropped points never reach the queue.
module point_height_grid_binning #(
    parameter int MAX_COLS = phgb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = phgb_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    input  phgb_pkg::t_item                   i_item,
    output logic                              full,
    output logic                              empty,
    input  logic                              pop,
    output phgb_pkg::t_result                 o_result,
    input  logic                              i_cfg_we,
    input  logic [phgb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int OPW   = $bits(phgb_pkg::t_op);
    localparam int QW    = AW + OPW;

    phgb_pkg::t_cfg  r_cfg;

    logic            clearing;
    logic            q_push;
    logic [AW-1:0]   q_addr;
    phgb_pkg::t_op   q_op;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    logic [QW-1:0]   q_head;
    logic [AW-1:0]   q_head_addr;
    phgb_pkg::t_op   q_head_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x         <= '0;
            r_cfg.origin_y         <= '0;
            r_cfg.inv_resolution   <= phgb_pkg::RST_INV_RESOLUTION;
            r_cfg.grid_width       <= phgb_pkg::RST_GRID_WIDTH;
            r_cfg.grid_height      <= phgb_pkg::RST_GRID_HEIGHT;
            r_cfg.height_ceiling   <= phgb_pkg::RST_CEILING;
            r_cfg.height_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                phgb_pkg::REG_ORIGIN_X:         r_cfg.origin_x         <= i_cfg_data;
                phgb_pkg::REG_ORIGIN_Y:         r_cfg.origin_y         <= i_cfg_data;
                phgb_pkg::REG_INV_RESOLUTION:   r_cfg.inv_resolution   <= i_cfg_data[24:0];
                phgb_pkg::REG_GRID_WIDTH:       r_cfg.grid_width       <= i_cfg_data[8:0];
                phgb_pkg::REG_GRID_HEIGHT:      r_cfg.grid_height      <= i_cfg_data[8:0];
                phgb_pkg::REG_HEIGHT_CEILING:   r_cfg.height_ceiling   <= i_cfg_data;
                phgb_pkg::REG_HEIGHT_THRESHOLD: r_cfg.height_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    phgb_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_cfg      (r_cfg),
        .i_clearing (clearing),
        .o_q_push   (q_push),
        .o_q_addr   (q_addr),
        .o_q_op     (q_op),
        .i_q_full   (q_full)
    );

    phgb_queue #(
        .WIDTH (QW),
        .DEPTH (phgb_pkg::QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({q_addr, q_op}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    assign q_head_addr = q_head[QW-1:OPW];
    assign q_head_op   = phgb_pkg::t_op'(q_head[OPW-1:0]);

    phgb_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_addr    (q_head_addr),
        .i_q_op      (q_head_op),
        .i_threshold (r_cfg.height_threshold),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    `PHGB_ASSERT_IMP(a_full_in_clear, clearing, full, "input open during clearing pass")
    `PHGB_ASSERT_IMP(a_push_room, q_push, !q_full, "front pushed into a full queue")
    `PHGB_ASSERT_IMP(a_pop_data, q_pop, !q_empty, "back popped an empty queue")
    `PHGB_ASSERT_NXT(a_pop_spacing, q_pop, !q_pop, "back popped on consecutive cycles")

endmodule

// ===== verif/point_height_grid_binning_test.sv =====
// Self-checking testbench for the point height grid binning block.
`timescale 1ns / 1ps

module point_height_grid_binning_test;
    import phgb_pkg::*;

    localparam int CELL_COUNT      = MAX_COLS_DEF * MAX_ROWS_DEF;
    localparam int BEATS_PER_PHASE = 90;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 300000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        t_item   beat;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    t_item                i_item;
    logic                 full;
    logic                 empty;
    logic                 pop;
    t_result              o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    t_cfg               grid_cfg;
    bit                 cell_occ [CELL_COUNT];
    logic signed [31:0] cell_lo  [CELL_COUNT];
    logic signed [31:0] cell_hi  [CELL_COUNT];
    logic [23:0]        cell_rgb [CELL_COUNT];
    t_result            pending_cells[$];
    t_dir_row           dir_rows[$];
    int                 mismatch_cnt;
    int                 stall_cycles;
    bit                 tx_calm;
    bit                 rx_calm;

    point_height_grid_binning u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit scale_to_cell(input longint diff, output longint idx);
        longint prod;
        prod = diff * longint'(grid_cfg.inv_resolution);
        idx  = 0;
        if (prod < 0) return ((-prod) >>> FRAC_BITS) == 0;
        idx = prod >>> FRAC_BITS;
        return 1'b1;
    endfunction

    function automatic bit bin_or_read_cell(input t_item it, output t_result res);
        longint      col;
        longint      row;
        longint      w;
        longint      h;
        int          c;
        logic [31:0] span;
        res = '0;
        if (it.command == CMD_ADD) begin
            w = grid_cfg.grid_width < MAX_COLS_DEF ? grid_cfg.grid_width : MAX_COLS_DEF;
            h = grid_cfg.grid_height < MAX_ROWS_DEF ? grid_cfg.grid_height : MAX_ROWS_DEF;
            if (!scale_to_cell(longint'(it.point_x) - longint'(grid_cfg.origin_x), col)
                || col >= w) return 1'b0;
            if (!scale_to_cell(longint'(grid_cfg.origin_y) - longint'(it.point_y), row)
                || row >= h) return 1'b0;
            if (it.point_z > grid_cfg.height_ceiling) return 1'b0;
            c = int'(row) * MAX_COLS_DEF + int'(col);
            if (!cell_occ[c]) begin
                cell_occ[c] = 1'b1;
                cell_lo[c]  = it.point_z;
                cell_hi[c]  = it.point_z;
                cell_rgb[c] = {it.red_in, it.green_in, it.blue_in};
            end else begin
                if (it.point_z < cell_lo[c]) cell_lo[c] = it.point_z;
                if (it.point_z > cell_hi[c]) begin
                    cell_hi[c]  = it.point_z;
                    cell_rgb[c] = {it.red_in, it.green_in, it.blue_in};
                end
            end
            return 1'b0;
        end
        c = int'(it.read_row) * MAX_COLS_DEF + int'(it.read_col);
        if (cell_occ[c]) begin
            span                  = cell_hi[c] - cell_lo[c];
            res.occupied          = 1'b1;
            res.exceeds_threshold = span > grid_cfg.height_threshold;
            res.height_span       = span;
            {res.red_out, res.green_out, res.blue_out} = cell_rgb[c];
        end
        if (it.clear_after_read) cell_occ[c] = 1'b0;
        return 1'b1;
    endfunction

    function automatic void check_cell(input t_result got);
        t_result want;
        if (pending_cells.size() == 0) begin
            if (mismatch_cnt < REPORT_LIMIT)
                $display("result beat with nothing pending: occ=%0b exc=%0b span=%08h %s%02h%02h%02h",
                         got.occupied, got.exceeds_threshold, got.height_span, "rgb=",
                         got.red_out, got.green_out, got.blue_out);
            mismatch_cnt++;
            return;
        end
        want = pending_cells.pop_front();
        if (got.occupied !== want.occupied || got.exceeds_threshold !== want.exceeds_threshold
            || got.height_span !== want.height_span || got.red_out !== want.red_out
            || got.green_out !== want.green_out || got.blue_out !== want.blue_out) begin
            if (mismatch_cnt < REPORT_LIMIT) begin
                $display("cell mismatch: exp occ=%0b exc=%0b span=%08h rgb=%02h%02h%02h",
                         want.occupied, want.exceeds_threshold, want.height_span,
                         want.red_out, want.green_out, want.blue_out);
                $display("               got occ=%0b exc=%0b span=%08h rgb=%02h%02h%02h",
                         got.occupied, got.exceeds_threshold, got.height_span,
                         got.red_out, got.green_out, got.blue_out);
            end
            mismatch_cnt++;
        end
    endfunction

    function automatic t_item add_beat(input logic signed [31:0] x, input logic signed [31:0] y,
                                       input logic signed [31:0] z, input logic [23:0] rgb,
                                       input logic clr);
        t_item it;
        it.command          = CMD_ADD;
        it.point_x          = x;
        it.point_y          = y;
        it.point_z          = z;
        {it.red_in, it.green_in, it.blue_in} = rgb;
        it.read_col         = 8'($urandom_range(0, 255));
        it.read_row         = 8'($urandom_range(0, 255));
        it.clear_after_read = clr;
        return it;
    endfunction

    function automatic t_item read_beat(input logic [7:0] col, input logic [7:0] row,
                                        input logic clr);
        t_item it;
        it.command          = CMD_READ;
        it.point_x          = $urandom;
        it.point_y          = $urandom;
        it.point_z          = $urandom;
        it.red_in           = 8'($urandom_range(0, 255));
        it.green_in         = 8'($urandom_range(0, 255));
        it.blue_in          = 8'($urandom_range(0, 255));
        it.read_col         = col;
        it.read_row         = row;
        it.clear_after_read = clr;
        return it;
    endfunction

    function automatic t_result cell_word(input logic occ, input logic exc,
                                          input logic [31:0] span, input logic [23:0] rgb);
        t_result res;
        res.occupied          = occ;
        res.exceeds_threshold = exc;
        res.height_span       = span;
        {res.red_out, res.green_out, res.blue_out} = rgb;
        return res;
    endfunction

    function automatic t_cfg grid_setting(input logic signed [31:0] ox, input logic signed [31:0] oy,
                                          input logic [24:0] inv, input logic [8:0] gw,
                                          input logic [8:0] gh, input logic signed [31:0] ceil_mm,
                                          input logic [31:0] thr);
        t_cfg c;
        c.origin_x         = ox;
        c.origin_y         = oy;
        c.inv_resolution   = inv;
        c.grid_width       = gw;
        c.grid_height      = gh;
        c.height_ceiling   = ceil_mm;
        c.height_threshold = thr;
        return c;
    endfunction

    function automatic void add_row(input t_item beat, input bit typed, input t_result want);
        t_dir_row row;
        row.beat  = beat;
        row.typed = typed;
        row.want  = want;
        dir_rows  = {dir_rows, row};
    endfunction

    function automatic longint place_mm(input longint cell_mm, input int reach);
        if ($urandom_range(0, 9) == 0) return -longint'($urandom_range(0, int'(2 * cell_mm)));
        return longint'($urandom_range(0, reach)) * cell_mm
               + longint'($urandom_range(0, int'(cell_mm - 1)));
    endfunction

    function automatic t_item random_beat();
        t_item  it;
        int     w_eff;
        int     h_eff;
        int     near_c;
        int     near_r;
        longint cell_mm;
        longint pos;
        it = read_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        w_eff  = grid_cfg.grid_width < MAX_COLS_DEF ? int'(grid_cfg.grid_width) : MAX_COLS_DEF;
        h_eff  = grid_cfg.grid_height < MAX_ROWS_DEF ? int'(grid_cfg.grid_height) : MAX_ROWS_DEF;
        near_c = w_eff < 8 ? w_eff : 8;
        near_r = h_eff < 8 ? h_eff : 8;
        if ($urandom_range(0, 99) < 35) begin
            if (near_c > 0 && near_r > 0 && $urandom_range(0, 4) != 0) begin
                it.read_col = 8'($urandom_range(0, near_c - 1));
                it.read_row = 8'($urandom_range(0, near_r - 1));
            end
            it.clear_after_read = $urandom_range(0, 3) == 0;
            return it;
        end
        it.command = CMD_ADD;
        if ($urandom_range(0, 99) < 18) return it;
        if (grid_cfg.inv_resolution != 0) begin
            cell_mm = (longint'(1) << FRAC_BITS) / longint'(grid_cfg.inv_resolution);
            if (cell_mm == 0) cell_mm = 1;
            pos = longint'(grid_cfg.origin_x)
                  + place_mm(cell_mm, $urandom_range(0, 7) == 0 ? w_eff : near_c);
            it.point_x = pos[31:0];
            pos = longint'(grid_cfg.origin_y)
                  - place_mm(cell_mm, $urandom_range(0, 7) == 0 ? h_eff : near_r);
            it.point_y = pos[31:0];
        end
        case ($urandom_range(0, 9))
            6: it.point_z = grid_cfg.height_ceiling;
            7: it.point_z = grid_cfg.height_ceiling + 1;
            8: it.point_z = $urandom;
            9: it.point_z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: it.point_z = int'($urandom_range(0, 4000)) - 2000;
        endcase
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input t_item beat, input bit typed, input t_result want);
        int      gap;
        t_result pred;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        if (bin_or_read_cell(beat, pred)) begin
            if (typed) pred = want;
            pending_cells = {pending_cells, pred};
        end
        @(negedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_cells.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    task automatic write_grid_cfg(input t_cfg c);
        put_reg(REG_ORIGIN_X, c.origin_x);
        put_reg(REG_ORIGIN_Y, c.origin_y);
        put_reg(REG_INV_RESOLUTION, 32'(c.inv_resolution));
        put_reg(REG_GRID_WIDTH, 32'(c.grid_width));
        put_reg(REG_GRID_HEIGHT, 32'(c.grid_height));
        put_reg(REG_HEIGHT_CEILING, c.height_ceiling);
        put_reg(REG_HEIGHT_THRESHOLD, c.height_threshold);
        i_cfg_we <= 1'b0;
        grid_cfg = c;
    endtask

    initial begin
        int       hold;
        int       r;
        hold = 0;
        pop  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else if (rx_calm) begin
                pop <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    hold = $urandom_range(0, 2);
                    pop  <= 1'b0;
                end else if (r < 13) begin
                    hold = $urandom_range(15, 60);
                    pop  <= 1'b0;
                end else begin
                    pop <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_cell(o_result);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((push && !full) || (pop && !empty))) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** point_height_grid_binning: FAILED **");
            $finish;
        end
    end

    initial begin
        t_cfg     phase_cfg[$];
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        mismatch_cnt = 0;
        stall_cycles = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        grid_cfg = grid_setting(0, 0, RST_INV_RESOLUTION, RST_GRID_WIDTH, RST_GRID_HEIGHT,
                                RST_CEILING, 0);
        foreach (cell_occ[i]) begin
            cell_occ[i] = 1'b0;
            cell_lo[i]  = '0;
            cell_hi[i]  = '0;
            cell_rgb[i] = '0;
        end

        add_row(read_beat(0, 0, 0), 1'b1, cell_word(0, 0, 0, 0));
        add_row(read_beat(255, 255, 1), 1'b1, cell_word(0, 0, 0, 0));
        add_row(add_beat(0, 0, 100, 24'hFF0000, 0), 1'b0, '0);
        add_row(add_beat(5, -5, 100, 24'h00FF00, 0), 1'b0, '0);
        add_row(add_beat(10, 0, -50, 24'h0000FF, 0), 1'b0, '0);
        add_row(read_beat(0, 0, 0), 1'b1, cell_word(1, 1, 150, 24'hFF0000));
        add_row(add_beat(0, 0, 3001, 24'h111111, 0), 1'b0, '0);
        add_row(add_beat(0, 0, 3000, 24'h123456, 0), 1'b0, '0);
        add_row(read_beat(0, 0, 1), 1'b1, cell_word(1, 1, 3050, 24'h123456));
        add_row(read_beat(0, 0, 0), 1'b1, cell_word(0, 0, 0, 0));
        add_row(add_beat(-1, 1, 7, 24'hABCDEF, 0), 1'b0, '0);
        add_row(add_beat(-20, 0, 5, 24'h222222, 0), 1'b0, '0);
        add_row(add_beat(5119, -5119, 32'h8000_0000, 24'h000000, 0), 1'b0, '0);
        add_row(add_beat(5121, -5119, 0, 24'h333333, 0), 1'b0, '0);
        add_row(add_beat(5100, -5100, 32'h7FFF_FFFF, 24'h444444, 0), 1'b0, '0);
        add_row(add_beat(5100, -5100, 3000, 24'hFFFFFF, 0), 1'b0, '0);
        add_row(read_beat(255, 255, 1), 1'b1, cell_word(1, 1, 32'h8000_0BB8, 24'hFFFFFF));
        add_row(read_beat(0, 0, 1), 1'b1, cell_word(1, 0, 0, 24'hABCDEF));
        add_row(add_beat(32'h7FFF_FFFF, 32'h8000_0000, 0, 24'h555555, 1), 1'b0, '0);
        add_row(add_beat(100, -100, -3, 24'h010203, 1), 1'b0, '0);
        add_row(add_beat(119, -119, -3, 24'h040506, 0), 1'b0, '0);
        add_row(read_beat(5, 5, 0), 1'b0, '0);
        add_row(read_beat(5, 5, 1), 1'b0, '0);
        add_row(read_beat(5, 5, 0), 1'b0, '0);

        phase_cfg = {phase_cfg, grid_setting(0, 0, 838861, 8, 8, 3000, 100)};
        phase_cfg = {phase_cfg, grid_setting(-1000, 2000, 25'd16777216, 16, 4, 0, 0)};
        phase_cfg = {phase_cfg, grid_setting(32'h8000_0000, 32'h7FFF_FFFF, 1, 256, 256,
                                             32'h7FFF_FFFF, 32'hFFFF_FFFF)};
        phase_cfg = {phase_cfg, grid_setting(32'h7FFF_FFFF, 32'h8000_0000, 0, 511, 300,
                                             32'h8000_0000, 5)};
        phase_cfg = {phase_cfg, grid_setting(100, -100, 25'h1FF_FFFF, 0, 3, 1000, 10)};
        phase_cfg = {phase_cfg, grid_setting(5, 5, 4194304, 1, 1, 500, 1000)};
        phase_cfg = {phase_cfg, grid_setting(0, 0, 838861, 256, 256, 3000, 0)};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);

        foreach (phase_cfg[p]) begin
            settle();
            write_grid_cfg(phase_cfg[p]);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n % 32 == 0) begin
                    tx_calm = $urandom_range(0, 3) == 0;
                    rx_calm = $urandom_range(0, 3) == 0;
                end
                send_beat(random_beat(), 1'b0, '0);
            end
        end

        settle();
        if (mismatch_cnt == 0 && pending_cells.size() == 0) begin
            $display("** point_height_grid_binning: PASSED **");
        end else begin
            $display("** point_height_grid_binning: FAILED **");
        end
        $finish;
    end

endmodule
